/* rtl/sorted_extent_table_merge_macros.svh */
// Assertion macros shared by the extent table RTL.
`ifndef SORTED_EXTENT_TABLE_MERGE_MACROS_SVH
`define SORTED_EXTENT_TABLE_MERGE_MACROS_SVH

// Checks that a condition never holds outside reset.
`define SETM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define SETM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define SETM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/setm_pkg.sv */
// Types, sizes and codes shared by the extent table modules.
package setm_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
  localparam int START_W     = 32;
  localparam int LEN_W       = 16;
  localparam int ENT_W       = START_W + LEN_W;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] ST_GREW_PREV = 3'd0;
  localparam logic [2:0] ST_GREW_NEXT = 3'd1;
  localparam logic [2:0] ST_NEW       = 3'd2;
  localparam logic [2:0] ST_COVERED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_LOOKUP    = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } entry_t;

endpackage

/* rtl/setm_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module setm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/sorted_extent_table_merge.sv */
// Top level of the sorted bad-block extent table with insert, lookup and clear.
//
//   Channel   Ports                               Handshake
//   --------  ----------------------------------  ------------------------------
//   command   in_cmd, in_block_number             start high while busy is low
//   result    out_status, out_found, out_extent_* out_valid high for one cycle
//
// A clear reports its result straight from idle. A lookup walks the table from
// entry 0 and finishes after reading the first extent that ends past the block,
// or after the last entry. An insert scans up to the insertion point p, passes
// through a decision state and, for a new extent, moves the n - p entries from p
// upward one place up, one per cycle through the RAM's read and write ports. The
// RAM's registered read sets the pace of both walks. Reset empties the table by
// clearing the extent count; the RAM itself is not cleared. Results cannot be
// stalled, and a new command may be issued in the cycle a result is shown.
`include "sorted_extent_table_merge_macros.svh"

module sorted_extent_table_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic [setm_pkg::START_W-1:0]        in_block_number,
  output logic                                out_valid,
  output logic [2:0]                          out_status,
  output logic                                out_found,
  output logic [setm_pkg::START_W-1:0]        out_extent_start,
  output logic [setm_pkg::LEN_W-1:0]          out_extent_length,
  output logic                                out_block_in_extent
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DEC,
    S_SHIFT
  } state_t;

  localparam int IDX_W = setm_pkg::IDX_W;
  localparam int CNT_W = setm_pkg::CNT_W;
  localparam int SW    = setm_pkg::START_W;
  localparam int LW    = setm_pkg::LEN_W;

  // Control state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;       // number of valid extents
  logic              dv_r, dv_nxt;         // RAM read data is valid this cycle

  // Working registers for the command in flight.
  logic              is_lookup_r, is_lookup_nxt;
  logic [SW-1:0]     bn_r, bn_nxt;
  logic [CNT_W-1:0]  a_r, a_nxt;           // next entry to read during the scan
  logic [CNT_W-1:0]  e_r, e_nxt;           // entry held in the read data
  logic [CNT_W-1:0]  p_r, p_nxt;           // insertion point
  logic              hn_r, hn_nxt;         // an entry exists at the insertion point
  setm_pkg::entry_t  prev_r, prev_nxt;     // entry just below the insertion point
  setm_pkg::entry_t  next_r, next_nxt;     // entry at the insertion point
  logic [CNT_W-1:0]  rem_r, rem_nxt;       // entries still to move up
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt; // next entry to read during the shift
  logic [IDX_W-1:0]  widx_r, widx_nxt;     // destination of the entry being moved

  // Result registers.
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic              out_found_r, out_found_nxt;
  logic [SW-1:0]     out_start_r, out_start_nxt;
  logic [LW-1:0]     out_len_r, out_len_nxt;
  logic              out_bie_r, out_bie_nxt;

  // RAM port signals.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  setm_pkg::entry_t  ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  setm_pkg::entry_t  ram_rdata;

  // Derived values on the read data and the held neighbors.
  logic [SW:0]       bn33;
  logic [SW:0]       ent_end;
  logic [SW:0]       prev_end;
  logic              stop_hit;
  logic              has_prev;

  setm_ram #(
    .WIDTH (setm_pkg::ENT_W),
    .DEPTH (setm_pkg::MAX_EXTENTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign bn33     = {1'b0, bn_r};
  assign ent_end  = {1'b0, ram_rdata.start} + {{(SW + 1 - LW){1'b0}}, ram_rdata.len};
  assign prev_end = {1'b0, prev_r.start} + {{(SW + 1 - LW){1'b0}}, prev_r.len};
  assign has_prev = (p_r != '0);

  // A lookup stops at the first extent that ends past the block. An insert
  // stops at the first extent whose start is at or above the block.
  assign stop_hit = dv_r && (is_lookup_r ? (ent_end > bn33) : !(bn_r > ram_rdata.start));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    dv_nxt         = 1'b0;
    is_lookup_nxt  = is_lookup_r;
    bn_nxt         = bn_r;
    a_nxt          = a_r;
    e_nxt          = e_r;
    p_nxt          = p_r;
    hn_nxt         = hn_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    rem_nxt        = rem_r;
    rd_idx_nxt     = rd_idx_r;
    widx_nxt       = widx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = 1'b0;
    out_start_nxt  = '0;
    out_len_nxt    = '0;
    out_bie_nxt    = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_cmd) inside
            setm_pkg::CMD_INSERT, setm_pkg::CMD_LOOKUP: begin
              is_lookup_nxt = (in_cmd == setm_pkg::CMD_LOOKUP);
              bn_nxt        = in_block_number;
              a_nxt         = '0;
              state_nxt     = S_SCAN;
            end
            setm_pkg::CMD_CLEAR: begin
              cnt_nxt        = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = setm_pkg::ST_CLEARED;
            end
            default: begin
              // The unused command code is dropped without a result.
            end
          endcase
        end
      end

      S_SCAN: begin
        if (dv_r && !stop_hit) begin
          prev_nxt = ram_rdata;
        end
        if (stop_hit) begin
          if (is_lookup_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = setm_pkg::ST_LOOKUP;
            out_found_nxt  = 1'b1;
            out_start_nxt  = ram_rdata.start;
            out_len_nxt    = ram_rdata.len;
            out_bie_nxt    = (ram_rdata.start <= bn_r);
            state_nxt      = S_IDLE;
          end else begin
            p_nxt     = e_r;
            next_nxt  = ram_rdata;
            hn_nxt    = 1'b1;
            state_nxt = S_DEC;
          end
        end else if (a_r == cnt_r) begin
          if (is_lookup_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = setm_pkg::ST_LOOKUP;
            state_nxt      = S_IDLE;
          end else begin
            p_nxt     = cnt_r;
            hn_nxt    = 1'b0;
            state_nxt = S_DEC;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = a_r[IDX_W-1:0];
          a_nxt     = a_r + CNT_W'(1);
          e_nxt     = a_r;
          dv_nxt    = 1'b1;
        end
      end

      S_DEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if ((has_prev && (bn33 < prev_end)) || (hn_r && (next_r.start == bn_r))) begin
          out_status_nxt = setm_pkg::ST_COVERED;
        end else if (has_prev && (bn33 == prev_end) && (prev_r.len != setm_pkg::LEN_MAX)) begin
          ram_we         = 1'b1;
          ram_waddr      = IDX_W'(p_r - CNT_W'(1));
          ram_wdata      = '{start: prev_r.start, len: prev_r.len + LW'(1)};
          out_status_nxt = setm_pkg::ST_GREW_PREV;
        end else if (hn_r && (next_r.start != '0) && (bn_r == next_r.start - SW'(1))
                     && (next_r.len != setm_pkg::LEN_MAX)) begin
          ram_we         = 1'b1;
          ram_waddr      = p_r[IDX_W-1:0];
          ram_wdata      = '{start: next_r.start - SW'(1), len: next_r.len + LW'(1)};
          out_status_nxt = setm_pkg::ST_GREW_NEXT;
        end else if (cnt_r == CNT_W'(setm_pkg::MAX_EXTENTS)) begin
          out_status_nxt = setm_pkg::ST_FULL;
        end else begin
          // Room for a new extent: move entries p..n-1 up by one first.
          out_valid_nxt = 1'b0;
          rem_nxt       = cnt_r - p_r;
          rd_idx_nxt    = IDX_W'(cnt_r - CNT_W'(1));
          state_nxt     = S_SHIFT;
        end
      end

      S_SHIFT: begin
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = widx_r;
          ram_wdata = ram_rdata;
        end
        if (rem_r != '0) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_idx_r;
          rd_idx_nxt = rd_idx_r - IDX_W'(1);
          widx_nxt   = rd_idx_r + IDX_W'(1);
          rem_nxt    = rem_r - CNT_W'(1);
          dv_nxt     = 1'b1;
        end else if (!dv_r) begin
          ram_we         = 1'b1;
          ram_waddr      = p_r[IDX_W-1:0];
          ram_wdata      = '{start: bn_r, len: LW'(1)};
          cnt_nxt        = cnt_r + CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = setm_pkg::ST_NEW;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      dv_r         <= dv_nxt;
      out_valid_r  <= out_valid_nxt;
      is_lookup_r  <= is_lookup_nxt;
      bn_r         <= bn_nxt;
      a_r          <= a_nxt;
      e_r          <= e_nxt;
      p_r          <= p_nxt;
      hn_r         <= hn_nxt;
      prev_r       <= prev_nxt;
      next_r       <= next_nxt;
      rem_r        <= rem_nxt;
      rd_idx_r     <= rd_idx_nxt;
      widx_r       <= widx_nxt;
      out_status_r <= out_status_nxt;
      out_found_r  <= out_found_nxt;
      out_start_r  <= out_start_nxt;
      out_len_r    <= out_len_nxt;
      out_bie_r    <= out_bie_nxt;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_found           = out_found_r;
  assign out_extent_start    = out_start_r;
  assign out_extent_length   = out_len_r;
  assign out_block_in_extent = out_bie_r;

  // The extent count never passes the table size.
  `SETM_ASSERT_NEVER(a_cnt_bound, cnt_r > CNT_W'(setm_pkg::MAX_EXTENTS), "extent count overflow")
  // The table RAM is written only while a command is in flight.
  `SETM_ASSERT_NEVER(a_write_idle, ram_we && (state_r == S_IDLE), "RAM write while idle")
  // Only a lookup reports a found extent.
  `SETM_ASSERT_IMPL(a_found_lookup, out_valid && out_found,
                    out_status == setm_pkg::ST_LOOKUP, "found on non-lookup")
  // An accepted insert keeps the block busy in the following cycle.
  `SETM_ASSERT_NEXT(a_insert_busy, start && !busy && (in_cmd == setm_pkg::CMD_INSERT),
                    busy, "insert not started")

endmodule

/* bench/tb_sorted_extent_table_merge.sv */
// Self-checking testbench for the sorted bad-block extent table: insert, lookup and clear.
module tb_sorted_extent_table_merge;
  timeunit 1ns;
  timeprecision 1ps;

  import setm_pkg::*;

  // The command code that the block must ignore without any result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The random part stops once this many recognized commands have been issued.
  localparam int RANDOM_ITEMS = 640;
  // The longest correct stretch without any handshake is a long idle gap plus a
  // full shifting insert. This limit lies well above that.
  localparam int IDLE_LIMIT = 1000;
  // Long enough for a shifting insert or a full lookup to finish.
  localparam int DRAIN_CYCLES = MAX_EXTENTS + 16;

  // The table is filled here.
  localparam logic [START_W-1:0] FILL_BASE = 32'h0000_1000;

  // All fields of one result item.
  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic [START_W-1:0] ext_start;
    logic [LEN_W-1:0]   ext_len;
    logic               in_ext;
  } reply_t;

  // A result still to come, with the command that caused it for the log.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [START_W-1:0] block;
    reply_t             reply;
  } reply_due_t;

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_TYPED,
    CHK_NONE
  } chk_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [START_W-1:0] block;
    chk_t               chk;
    reply_t             reply;
  } directed_row_t;

  localparam reply_t NO_REPLY = '0;
  localparam int NUM_ROWS = 25;

  // Directed rows. The typed results can be read straight off the rules: an
  // empty table, single-block extents at the very top and bottom of the block
  // range, a block already covered, and a clear. The predicted rows build
  // neighbors, some that touch without being fused, and go through the predictor.
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{CMD_LOOKUP, 32'h0000_0000, CHK_TYPED, '{ST_LOOKUP, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_LOOKUP, 32'hFFFF_FFFF, CHK_TYPED, '{ST_LOOKUP, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_INSERT, 32'hFFFF_FFFF, CHK_TYPED, '{ST_NEW, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_LOOKUP, 32'hFFFF_FFFF, CHK_TYPED,
      '{ST_LOOKUP, 1'b1, 32'hFFFF_FFFF, 16'h1, 1'b1}},
    '{CMD_INSERT, 32'hFFFF_FFFF, CHK_TYPED, '{ST_COVERED, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_INSERT, 32'hFFFF_FFFE, CHK_TYPED, '{ST_GREW_NEXT, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_INSERT, 32'h0000_0000, CHK_TYPED, '{ST_NEW, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_INSERT, 32'h0000_0001, CHK_TYPED, '{ST_GREW_PREV, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_LOOKUP, 32'h0000_0000, CHK_TYPED, '{ST_LOOKUP, 1'b1, 32'h0, 16'h2, 1'b1}},
    '{CMD_LOOKUP, 32'h0000_0002, CHK_TYPED,
      '{ST_LOOKUP, 1'b1, 32'hFFFF_FFFE, 16'h2, 1'b0}},
    '{CMD_INSERT, 32'h0000_0001, CHK_TYPED, '{ST_COVERED, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_UNUSED, 32'h5555_AAAA, CHK_NONE,    NO_REPLY},
    '{CMD_INSERT, 32'h0000_0003, CHK_PREDICT, NO_REPLY},
    '{CMD_INSERT, 32'h0000_0002, CHK_PREDICT, NO_REPLY},
    '{CMD_LOOKUP, 32'h0000_0002, CHK_PREDICT, NO_REPLY},
    '{CMD_LOOKUP, 32'h0000_0003, CHK_PREDICT, NO_REPLY},
    '{CMD_INSERT, 32'h8000_0000, CHK_PREDICT, NO_REPLY},
    '{CMD_LOOKUP, 32'h7FFF_FFFF, CHK_PREDICT, NO_REPLY},
    '{CMD_INSERT, 32'h7FFF_FFFF, CHK_PREDICT, NO_REPLY},
    '{CMD_UNUSED, 32'hAAAA_5555, CHK_NONE,    NO_REPLY},
    '{CMD_INSERT, 32'hAAAA_AAAA, CHK_PREDICT, NO_REPLY},
    '{CMD_LOOKUP, 32'h5555_5555, CHK_PREDICT, NO_REPLY},
    '{CMD_CLEAR,  32'h0000_0000, CHK_TYPED,   '{ST_CLEARED, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_LOOKUP, 32'h0000_0003, CHK_TYPED,   '{ST_LOOKUP, 1'b0, 32'h0, 16'h0, 1'b0}},
    '{CMD_INSERT, 32'h5555_5555, CHK_TYPED,   '{ST_NEW, 1'b0, 32'h0, 16'h0, 1'b0}}
  };

  // Every input is known from time zero.
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [1:0]         in_cmd = CMD_INSERT;
  logic [START_W-1:0] in_block_number = '0;

  logic               busy;
  logic               out_valid;
  logic [2:0]         out_status;
  logic               out_found;
  logic [START_W-1:0] out_extent_start;
  logic [LEN_W-1:0]   out_extent_length;
  logic               out_block_in_extent;

  // Shadow copy of the extent table. Entries at or past the count are stale.
  logic [START_W-1:0] ext_starts [MAX_EXTENTS];
  logic [LEN_W-1:0]   ext_lens [MAX_EXTENTS];
  int                 ext_count = 0;

  reply_due_t replies_due [$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  bit         quiet = 1'b0;

  sorted_extent_table_merge dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_found           (out_found),
    .out_extent_start    (out_extent_start),
    .out_extent_length   (out_extent_length),
    .out_block_in_extent (out_block_in_extent)
  );

  always #4 clk = ~clk;

  // One past the last block of extent i, at 33 bits so that an extent may end
  // exactly at the top of the block range without wrapping.
  function automatic logic [START_W:0] extent_end(input int i);
    return (START_W+1)'(ext_starts[i]) + (START_W+1)'(ext_lens[i]);
  endfunction

  // Applies one command to the shadow table. Returns 1 with the result fields
  // when the command produces a result, 0 for the ignored command code.
  function automatic bit extent_table_apply(input logic [1:0] cmd,
                                            input logic [START_W-1:0] block,
                                            output reply_t reply);
    int p;
    reply = '0;
    case (cmd)
      CMD_INSERT: begin
        // p is the first extent that starts at or above the block.
        p = 0;
        while (p < ext_count && block > ext_starts[p])
          p++;
        if (p > 0 && (START_W+1)'(block) < extent_end(p - 1)) begin
          reply.status = ST_COVERED;
        end else if (p < ext_count && ext_starts[p] == block) begin
          reply.status = ST_COVERED;
        end else if (p > 0 && (START_W+1)'(block) == extent_end(p - 1) &&
                     ext_lens[p - 1] != LEN_MAX) begin
          ext_lens[p - 1]++;
          reply.status = ST_GREW_PREV;
        end else if (p < ext_count && ext_starts[p] != '0 &&
                     block == ext_starts[p] - 1 && ext_lens[p] != LEN_MAX) begin
          ext_starts[p]--;
          ext_lens[p]++;
          reply.status = ST_GREW_NEXT;
        end else if (ext_count >= MAX_EXTENTS) begin
          reply.status = ST_FULL;
        end else begin
          for (int k = ext_count; k > p; k--) begin
            ext_starts[k] = ext_starts[k - 1];
            ext_lens[k]   = ext_lens[k - 1];
          end
          ext_starts[p] = block;
          ext_lens[p]   = 1;
          ext_count++;
          reply.status = ST_NEW;
        end
        return 1'b1;
      end
      CMD_LOOKUP: begin
        reply.status = ST_LOOKUP;
        for (int i = 0; i < ext_count; i++) begin
          if (extent_end(i) > (START_W+1)'(block)) begin
            reply.found     = 1'b1;
            reply.ext_start = ext_starts[i];
            reply.ext_len   = ext_lens[i];
            reply.in_ext    = (ext_starts[i] <= block);
            break;
          end
        end
        return 1'b1;
      end
      CMD_CLEAR: begin
        ext_count = 0;
        reply.status = ST_CLEARED;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Idle gap before a command: mostly none or short, now and then long. A quiet
  // stretch issues back to back.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 40)
      return 0;
    if (roll < 85)
      return $urandom_range(1, 3);
    if (roll < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one command and returns in the time step of the clock edge that
  // accepted it, having queued the result it will cause. A typed result, where
  // given, stands in for the predicted one. The caller must not touch the
  // command ports again within that time step except through this task.
  task automatic issue_cmd(input logic [1:0] cmd, input logic [START_W-1:0] block,
                           input bit use_typed, input reply_t typed_reply);
    int         gap;
    reply_t     predicted;
    reply_due_t due;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_cmd          <= cmd;
    in_block_number <= block;
    // Values read here are those from before the edge, so busy is the value the
    // block acted on.
    do
      @(posedge clk);
    while (busy);
    if (extent_table_apply(cmd, block, predicted)) begin
      due.cmd   = cmd;
      due.block = block;
      due.reply = use_typed ? typed_reply : predicted;
      replies_due.push_back(due);
    end
  endtask

  task automatic compare_field(input string name, input reply_due_t due,
                               input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch (cmd %0d, block %h): expected %h, got %h",
               $time, name, due.cmd, due.block, want, got);
      mismatch_count++;
    end
  endtask

  // Results cannot be held off, so each strobe is taken as it comes and checked
  // against the oldest result still awaited. An unknown strobe counts as a result.
  always @(posedge clk) begin : check_replies
    reply_due_t due;
    if (rst_n && out_valid !== 1'b0) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with no command pending: status %h, start %h, length %h",
                 $time, out_status, out_extent_start, out_extent_length);
        mismatch_count++;
      end else begin
        due = replies_due.pop_front();
        compare_field("status", due, 32'(due.reply.status), 32'(out_status));
        compare_field("found", due, 32'(due.reply.found), 32'(out_found));
        compare_field("extent_start", due, due.reply.ext_start, out_extent_start);
        compare_field("extent_length", due, 32'(due.reply.ext_len),
                      32'(out_extent_length));
        compare_field("block_in_extent", due, 32'(due.reply.in_ext),
                      32'(out_block_in_extent));
      end
    end
  end

  // Watchdog: any accepted command or shown result restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results still awaited",
               $time, IDLE_LIMIT, replies_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          counted;
    int          mode;
    int          stride;
    int          slots;
    int          phase_len;
    int          roll;
    logic [1:0]  cmd;
    logic [START_W-1:0] base;
    logic [START_W-1:0] block;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, one row per command.
    foreach (DIRECTED_ROWS[r])
      issue_cmd(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].block,
                DIRECTED_ROWS[r].chk == CHK_TYPED, DIRECTED_ROWS[r].reply);

    // Fill the table with isolated blocks and run past the capacity. Blocks that
    // only grow an extent are still taken while the table is full.
    for (int k = 0; k < MAX_EXTENTS + 2; k++)
      issue_cmd(CMD_INSERT, FILL_BASE + 2 * k, 1'b0, NO_REPLY);
    issue_cmd(CMD_INSERT, FILL_BASE + 1, 1'b0, NO_REPLY);
    issue_cmd(CMD_INSERT, FILL_BASE + 2 * MAX_EXTENTS + 4, 1'b0, NO_REPLY);
    issue_cmd(CMD_LOOKUP, FILL_BASE + 2 * MAX_EXTENTS, 1'b0, NO_REPLY);
    issue_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0, NO_REPLY);

    // Random part in phases. Each phase works in one window of block numbers so
    // that blocks often land next to or inside extents. Dense windows grow
    // extents, spaced windows build many small neighbors and fill the table,
    // the edge windows sit at either end of the range, and the last mode is
    // fully random. Most phases keep the table of the phase before.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 4);
      base = $urandom;
      case (mode)
        0: begin stride = 1; slots = 48; end
        1: begin stride = 2; slots = 96; end
        2: begin stride = 4; slots = 96; end
        3: begin
          stride = 1;
          slots  = 128;
          base   = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FF80;
        end
        default: begin stride = 1; slots = 1; end
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 120);
      if ($urandom_range(0, 2) == 0) begin
        issue_cmd(CMD_CLEAR, $urandom, 1'b0, NO_REPLY);
        counted++;
      end
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 66)
          cmd = CMD_INSERT;
        else if (roll < 95)
          cmd = CMD_LOOKUP;
        else if (roll < 96)
          cmd = CMD_CLEAR;
        else
          cmd = CMD_UNUSED;
        if (mode == 4 || $urandom_range(0, 19) == 0) begin
          block = $urandom;
        end else begin
          block = base + stride * $urandom_range(0, slots - 1);
          if ($urandom_range(0, 3) == 0)
            block = block + $urandom_range(0, stride - 1);
        end
        issue_cmd(cmd, block, 1'b0, NO_REPLY);
        if (cmd != CMD_UNUSED)
          counted++;
      end
    end

    // Drop start in the step of the last acceptance, then wait for every
    // result, then long enough for a stray one to show.
    start <= 1'b0;
    while (replies_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && replies_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/setm_pkg.sv
rtl/setm_ram.sv
rtl/sorted_extent_table_merge.sv
bench/tb_sorted_extent_table_merge.sv
